FILE: design/delta_list_task_scheduler_macros.svh
// Assertion macros for the task scheduler.
`ifndef DELTA_LIST_TASK_SCHEDULER_MACROS_SVH
`define DELTA_LIST_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define DLTS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define DLTS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define DLTS_ASSERT_IMP(label, clk, rst_n, a, c)
`define DLTS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: design/dlts_pkg.sv
package dlts_pkg;
    localparam int SLOTS_DEF       = 16;
    localparam int DELAY_BITS_DEF  = 32;
    localparam int ID_BITS_DEF     = 16;
    localparam int HANDLE_BITS_DEF = 8;
    localparam int OUT_ID_BITS     = 16;
    localparam int OUT_RUN_BITS    = 8;
    localparam int TARGET_BITS     = 16;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_DISPATCH = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_SCAN,
        ST_ADD_SHIFT,
        ST_ADD_PLACE,
        ST_DEL_SCAN,
        ST_DEL_SHIFT,
        ST_TICK,
        ST_DISP_TAKE,
        ST_RESULT,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic scan_clr;
        logic scan_step;
        logic add_split;
        logic add_shift;
        logic add_place;
        logic del_fold;
        logic del_shift;
        logic del_clear;
        logic tick_head;
        logic disp_take;
        logic load_redo;
        logic res_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       head_due;
        logic       scan_end;
        logic       scan_hit;
        logic       shift_end;
        logic       target_zero;
        logic       redo;
    } t_stat;
endpackage

FILE: design/dlts_if.sv
interface dlts_in_if import dlts_pkg::*; #(
    parameter int DELAY_BITS  = DELAY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    logic [HANDLE_BITS-1:0] task_handle;
    logic [DELAY_BITS-1:0]  first_delay;
    logic [DELAY_BITS-1:0]  repeat_period;
    logic [TARGET_BITS-1:0] target_id;
    modport source (output valid, opcode, task_handle, first_delay, repeat_period,
                    target_id, input ready);
    modport sink (input valid, opcode, task_handle, first_delay, repeat_period,
                  target_id, output ready);
endinterface

interface dlts_out_if import dlts_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic [1:0]              op_echo;
    logic                    success;
    logic [OUT_ID_BITS-1:0]  assigned_id;
    logic [OUT_RUN_BITS-1:0] run_handle;
    modport source (output valid, op_echo, success, assigned_id, run_handle, input ready);
    modport sink (input valid, op_echo, success, assigned_id, run_handle, output ready);
endinterface

FILE: design/dlts_ctrl.sv
module dlts_ctrl import dlts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.scan_clr = 1'b1;
                case (i_stat.op)
                    OP_ADD:    n_state = i_stat.full ? ST_RESULT : ST_ADD_SCAN;
                    OP_DELETE: n_state = i_stat.target_zero ? ST_RESULT : ST_DEL_SCAN;
                    OP_TICK:   n_state = ST_TICK;
                    default:   n_state = (!i_stat.empty && i_stat.head_due)
                                         ? ST_DISP_TAKE : ST_RESULT;
                endcase
            end
            ST_ADD_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = ST_ADD_PLACE;
                end else if (i_stat.scan_hit) begin
                    o_cmd.add_split = 1'b1;
                    n_state = ST_ADD_SHIFT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_ADD_SHIFT: begin
                if (i_stat.shift_end) begin
                    n_state = ST_ADD_PLACE;
                end else begin
                    o_cmd.add_shift = 1'b1;
                end
            end
            ST_ADD_PLACE: begin
                o_cmd.add_place = 1'b1;
                n_state = ST_RESULT;
            end
            ST_DEL_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = ST_RESULT;
                end else if (i_stat.scan_hit) begin
                    o_cmd.del_fold = 1'b1;
                    n_state = ST_DEL_SHIFT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_DEL_SHIFT: begin
                if (i_stat.shift_end) begin
                    o_cmd.del_clear = 1'b1;
                    n_state = i_stat.redo ? ST_ADD_SCAN : ST_RESULT;
                    o_cmd.load_redo = i_stat.redo;
                end else begin
                    o_cmd.del_shift = 1'b1;
                end
            end
            ST_TICK: begin
                o_cmd.tick_head = 1'b1;
                n_state = ST_RESULT;
            end
            ST_DISP_TAKE: begin
                o_cmd.disp_take = 1'b1;
                o_cmd.scan_clr  = 1'b1;
                n_state = ST_DEL_SHIFT;
            end
            ST_RESULT: begin
                o_cmd.res_load = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

FILE: design/dlts_datapath.sv
module dlts_datapath import dlts_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int DELAY_BITS  = DELAY_BITS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [1:0]              i_opcode,
    input  logic [HANDLE_BITS-1:0]  i_task_handle,
    input  logic [DELAY_BITS-1:0]   i_first_delay,
    input  logic [DELAY_BITS-1:0]   i_repeat_period,
    input  logic [TARGET_BITS-1:0]  i_target_id,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic [1:0]              o_op_echo,
    output logic                    o_success,
    output logic [OUT_ID_BITS-1:0]  o_assigned_id,
    output logic [OUT_RUN_BITS-1:0] o_run_handle
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = DELAY_BITS + 1;
    localparam int XW = ID_BITS + TARGET_BITS;

    logic [SLOTS-1:0]       r_used;
    logic [SLOTS-1:0]       r_due;
    logic [HANDLE_BITS-1:0] r_handle [SLOTS];
    logic [DELAY_BITS-1:0]  r_delta  [SLOTS];
    logic [DELAY_BITS-1:0]  r_period [SLOTS];
    logic [ID_BITS-1:0]     r_ident  [SLOTS];
    logic [ID_BITS-1:0]     r_idc;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_k;     // scan index / shift index
    logic [IW-1:0]          r_pos;
    logic [SW-1:0]          r_sum;
    logic [SW-1:0]          r_before;
    logic [1:0]             r_op;
    logic [1:0]             r_echo;  // opcode as received, kept across a re-add
    logic [HANDLE_BITS-1:0] r_h;
    logic [DELAY_BITS-1:0]  r_d;
    logic [DELAY_BITS-1:0]  r_p;
    logic [TARGET_BITS-1:0] r_tgt;
    logic                   r_ok;
    logic [OUT_ID_BITS-1:0] r_id;
    logic [OUT_RUN_BITS-1:0] r_run;
    logic                   r_redo;
    logic [HANDLE_BITS-1:0] r_rh;
    logic [DELAY_BITS-1:0]  r_rp;

    logic [IW-1:0]         k_ix;
    logic [SW-1:0]         sum_nx;
    logic [ID_BITS-1:0]    id_a, id_nx;
    logic [DELAY_BITS-1:0] fold;

    assign k_ix   = r_k[IW-1:0];
    assign sum_nx = r_sum + {1'b0, r_delta[k_ix]};
    assign id_a   = r_idc + 1'b1;
    assign id_nx  = (id_a == '0) ? ID_BITS'(1) : id_a;
    assign fold   = r_delta[k_ix] + r_delta[IW'(r_k + 1'b1)];

    always_comb begin
        o_stat             = '0;
        o_stat.op          = r_op;
        o_stat.full        = (r_count == CW'(SLOTS));
        o_stat.empty       = (r_count == '0);
        o_stat.head_due    = r_due[0];
        o_stat.scan_end    = (r_k == r_count);
        o_stat.target_zero = (r_tgt == '0);
        o_stat.redo        = r_redo;
        if (r_op == OP_DELETE) begin
            o_stat.scan_hit = (XW'(r_ident[k_ix]) == XW'(r_tgt));
        end else begin
            o_stat.scan_hit = (sum_nx > {1'b0, r_d});
        end
        // add shifts down from count to pos; delete shifts up to count-1
        if (r_op == OP_ADD) begin
            o_stat.shift_end = (r_k == CW'(r_pos));
        end else begin
            o_stat.shift_end = (r_k + 1'b1 >= r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_due   <= '0;
            r_idc   <= '0;
            r_count <= '0;
            r_redo  <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_handle[i] <= '0;
                r_delta[i]  <= '0;
                r_period[i] <= '0;
                r_ident[i]  <= '0;
            end
        end else begin
            if (i_cmd.load_item) begin
                r_op   <= i_opcode;
                r_echo <= i_opcode;
                r_h    <= i_task_handle;
                r_d    <= i_first_delay;
                r_p    <= i_repeat_period;
                r_tgt  <= i_target_id;
                r_ok   <= 1'b0;
                r_id   <= '0;
                r_run  <= '0;
                r_redo <= 1'b0;
            end
            if (i_cmd.scan_clr) begin
                r_k      <= '0;
                r_sum    <= '0;
                r_before <= '0;
                r_pos    <= IW'(r_count);
            end
            if (i_cmd.scan_step) begin
                r_k      <= r_k + 1'b1;
                r_before <= sum_nx;
                r_sum    <= sum_nx;
            end
            if (i_cmd.add_split) begin
                r_pos        <= k_ix;
                r_sum        <= sum_nx;
                r_delta[k_ix] <= DELAY_BITS'(sum_nx - {1'b0, r_d});
                r_due[k_ix]   <= (DELAY_BITS'(sum_nx - {1'b0, r_d}) == '0);
                r_k          <= r_count;
            end
            if (i_cmd.add_shift) begin
                r_used[k_ix]   <= r_used[IW'(r_k - 1'b1)];
                r_due[k_ix]    <= r_due[IW'(r_k - 1'b1)];
                r_handle[k_ix] <= r_handle[IW'(r_k - 1'b1)];
                r_delta[k_ix]  <= r_delta[IW'(r_k - 1'b1)];
                r_period[k_ix] <= r_period[IW'(r_k - 1'b1)];
                r_ident[k_ix]  <= r_ident[IW'(r_k - 1'b1)];
                r_k            <= r_k - 1'b1;
            end
            if (i_cmd.add_place) begin
                r_used[r_pos]   <= 1'b1;
                r_handle[r_pos] <= r_h;
                r_delta[r_pos]  <= DELAY_BITS'({1'b0, r_d} - r_before);
                r_due[r_pos]    <= (DELAY_BITS'({1'b0, r_d} - r_before) == '0);
                r_period[r_pos] <= r_p;
                r_ident[r_pos]  <= id_nx;
                r_idc           <= id_nx;
                r_count         <= r_count + 1'b1;
                // a re-add after dispatch keeps the dispatched task's answer
                if (r_echo == OP_ADD) begin
                    r_ok <= 1'b1;
                    r_id <= OUT_ID_BITS'(id_nx);
                end
            end
            if (i_cmd.disp_take) begin
                r_ok   <= 1'b1;
                r_id   <= OUT_ID_BITS'(r_ident[0]);
                r_run  <= OUT_RUN_BITS'(r_handle[0]);
                r_rh   <= r_handle[0];
                r_rp   <= r_period[0];
                r_redo <= (r_period[0] != '0);
                if (r_count > CW'(1)) begin
                    r_delta[1] <= r_delta[0] + r_delta[1];
                    r_due[1]   <= ((r_delta[0] + r_delta[1]) == '0);
                end
            end
            if (i_cmd.del_fold) begin
                r_ok <= 1'b1;
                if (r_k + 1'b1 < r_count) begin
                    r_delta[IW'(r_k + 1'b1)] <= fold;
                    r_due[IW'(r_k + 1'b1)]   <= (fold == '0);
                end
            end
            if (i_cmd.del_shift) begin
                r_used[k_ix]   <= r_used[IW'(r_k + 1'b1)];
                r_due[k_ix]    <= r_due[IW'(r_k + 1'b1)];
                r_handle[k_ix] <= r_handle[IW'(r_k + 1'b1)];
                r_delta[k_ix]  <= r_delta[IW'(r_k + 1'b1)];
                r_period[k_ix] <= r_period[IW'(r_k + 1'b1)];
                r_ident[k_ix]  <= r_ident[IW'(r_k + 1'b1)];
                r_k            <= r_k + 1'b1;
            end
            if (i_cmd.del_clear) begin
                r_used[IW'(r_count - 1'b1)]   <= 1'b0;
                r_due[IW'(r_count - 1'b1)]    <= 1'b0;
                r_handle[IW'(r_count - 1'b1)] <= '0;
                r_delta[IW'(r_count - 1'b1)]  <= '0;
                r_period[IW'(r_count - 1'b1)] <= '0;
                r_ident[IW'(r_count - 1'b1)]  <= '0;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.load_redo) begin
                // re-add the dispatched task as an add of its own period
                r_h      <= r_rh;
                r_d      <= r_rp;
                r_p      <= r_rp;
                r_redo   <= 1'b0;
                r_op     <= OP_ADD;
                r_k      <= '0;
                r_sum    <= '0;
                r_before <= '0;
                r_pos    <= IW'(r_count - 1'b1);
            end
            if (i_cmd.tick_head && r_count != '0 && !r_due[0]) begin
                if (r_delta[0] != '0) r_delta[0] <= r_delta[0] - 1'b1;
                if (r_delta[0] <= DELAY_BITS'(1)) r_due[0] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_op_echo     <= r_echo;
            o_success     <= r_ok;
            o_assigned_id <= r_id;
            o_run_handle  <= r_run;
        end
    end
endmodule

FILE: design/delta_list_task_scheduler.sv
// Delta-list task scheduler.
// Refused ops and tick need no table scan; add and delete move one table entry per
// cycle, and a dispatch that re-adds a periodic task runs a delete and then an add.
// Throughput: one item in flight; the next item is accepted the cycle after the result is taken.
// Reset (i_rst_n low, synchronous): table emptied, id counter cleared.
`include "delta_list_task_scheduler_macros.svh"
module delta_list_task_scheduler import dlts_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int DELAY_BITS  = DELAY_BITS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dlts_in_if.sink    in_ch,
    dlts_out_if.source out_ch
);
    t_cmd  cmd;
    t_stat stat;

    // controller sequences scan, shift and result steps
    dlts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath holds the sorted table, one entry moved per cycle
    dlts_datapath #(
        .SLOTS(SLOTS), .DELAY_BITS(DELAY_BITS), .ID_BITS(ID_BITS),
        .HANDLE_BITS(HANDLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (in_ch.opcode),
        .i_task_handle   (in_ch.task_handle),
        .i_first_delay   (in_ch.first_delay),
        .i_repeat_period (in_ch.repeat_period),
        .i_target_id     (in_ch.target_id),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_op_echo       (out_ch.op_echo),
        .o_success       (out_ch.success),
        .o_assigned_id   (out_ch.assigned_id),
        .o_run_handle    (out_ch.run_handle)
    );

    // never take an item while a result is pending
    `DLTS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, out_ch.valid, !in_ch.ready)
    // a tick never reports success
    `DLTS_ASSERT_IMP(a_tick_fail, i_clk, i_rst_n,
        out_ch.valid && out_ch.op_echo == OP_TICK, !out_ch.success)
    // an accepted item moves the controller off idle
    `DLTS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
endmodule

FILE: tb/sv/tb_delta_list_task_scheduler.sv
`timescale 1ns / 1ps

module tb_delta_list_task_scheduler;
    import dlts_pkg::*;

    localparam int TABLE_DEPTH = SLOTS_DEF;

    typedef struct {
        logic [1:0]  op;
        logic        ok;
        logic [15:0] id;
        logic [7:0]  run;
    } sched_result_t;

    // Count one mismatch and print a single line describing it.
    int mismatch_count = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch: %s at %0t", what, $realtime);
    endtask

    // Shadow copy of the delta table; predicts every answer of the block.
    class sched_scoreboard;
        logic        used [TABLE_DEPTH];
        logic [7:0]  handle [TABLE_DEPTH];
        logic [31:0] delta [TABLE_DEPTH];
        logic [31:0] period [TABLE_DEPTH];
        logic        due [TABLE_DEPTH];
        logic [15:0] ident [TABLE_DEPTH];
        logic [15:0] id_ctr;
        sched_result_t pending_results[$];

        function new();
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                used[k] = 0; handle[k] = 0; delta[k] = 0;
                period[k] = 0; due[k] = 0; ident[k] = 0;
            end
            id_ctr = 0;
        endfunction

        function int occupancy();
            int n;
            n = 0;
            while (n < TABLE_DEPTH && used[n]) n++;
            return n;
        endfunction

        function void move_entry(int dst, int src);
            used[dst] = used[src]; handle[dst] = handle[src];
            delta[dst] = delta[src]; period[dst] = period[src];
            due[dst] = due[src]; ident[dst] = ident[src];
        endfunction

        function logic [15:0] insert_task(logic [7:0] h, logic [31:0] dly, logic [31:0] per);
            int n, pos;
            logic [32:0] acc, prev;
            logic [31:0] nd;
            n = occupancy();
            pos = n;
            acc = 0;
            prev = 0;
            if (n >= TABLE_DEPTH) return 16'h0;
            for (int k = 0; k < n; k++) begin
                prev = acc;
                acc = acc + delta[k];
                if (acc > {1'b0, dly}) begin
                    pos = k;
                    break;
                end
            end
            if (pos < n) begin
                nd = dly - prev[31:0];
                delta[pos] = 32'(acc - {1'b0, dly});
                due[pos] = (delta[pos] == 0);
                for (int k = n; k > pos; k--) move_entry(k, k - 1);
            end else begin
                nd = dly - acc[31:0];
            end
            used[pos] = 1; handle[pos] = h; delta[pos] = nd;
            period[pos] = per; due[pos] = (nd == 0);
            id_ctr = id_ctr + 16'd1;
            if (id_ctr == 0) id_ctr = 16'd1;
            ident[pos] = id_ctr;
            return id_ctr;
        endfunction

        function void drop_entry(int k, int n);
            if (k + 1 < n) begin
                delta[k+1] = delta[k+1] + delta[k];
                due[k+1] = (delta[k+1] == 0);
            end
            for (int j = k; j + 1 < n; j++) move_entry(j, j + 1);
            if (n > 0) begin
                used[n-1] = 0; handle[n-1] = 0; delta[n-1] = 0;
                period[n-1] = 0; due[n-1] = 0; ident[n-1] = 0;
            end
        endfunction

        // Note an accepted input item and queue its expected answer.
        function void note_item(logic [1:0] op, logic [7:0] h, logic [31:0] dly,
                                logic [31:0] per, logic [15:0] tgt);
            sched_result_t r;
            int n;
            logic [7:0] hh;
            logic [31:0] pp;
            n = occupancy();
            r.op = op; r.ok = 0; r.id = 0; r.run = 0;
            case (op)
                OP_ADD: begin
                    r.id = insert_task(h, dly, per);
                    r.ok = (r.id != 0);
                end
                OP_DELETE: begin
                    if (tgt != 0) begin
                        for (int k = 0; k < n; k++) begin
                            if (ident[k] == tgt) begin
                                drop_entry(k, n);
                                r.ok = 1;
                                break;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (n > 0 && !due[0]) begin
                        if (delta[0] > 0) delta[0]--;
                        if (delta[0] == 0) due[0] = 1;
                    end
                end
                default: begin
                    if (n > 0 && due[0]) begin
                        hh = handle[0];
                        pp = period[0];
                        r.ok = 1; r.id = ident[0]; r.run = hh;
                        drop_entry(0, n);
                        if (pp != 0) void'(insert_task(hh, pp, pp));
                    end
                end
            endcase
            pending_results.push_back(r);
        endfunction

        // Check one result against the oldest expectation.
        task check_result(logic [1:0] op, logic ok, logic [15:0] id, logic [7:0] run);
            sched_result_t e;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
                return;
            end
            e = pending_results.pop_front();
            if (op !== e.op)
                report_mismatch($sformatf("op_echo %0d want %0d", op, e.op));
            if (ok !== e.ok)
                report_mismatch($sformatf("success %0b want %0b (op %0d)", ok, e.ok, e.op));
            if (id !== e.id)
                report_mismatch($sformatf("assigned_id %0h want %0h (op %0d)", id, e.id, e.op));
            if (run !== e.run)
                report_mismatch($sformatf("run_handle %0h want %0h (op %0d)", run, e.run, e.op));
        endtask

        // Pick an id that is live in the table, or zero when it is empty.
        function logic [15:0] live_id();
            int n;
            n = occupancy();
            if (n == 0) return 16'h0;
            return ident[$urandom_range(n - 1, 0)];
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;

    dlts_in_if  in_ch ();
    dlts_out_if out_ch ();

    delta_list_task_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    sched_scoreboard sb = new();

    // Idle bursts switch off near the end; a long hold-off on the result side
    // is requested by the stimulus process and counted down here.
    bit idle_enable = 1;
    int long_hold_cycles = 0;

    initial begin
        in_ch.valid = 0;
        in_ch.opcode = OP_TICK;
        in_ch.task_handle = 0;
        in_ch.first_delay = 0;
        in_ch.repeat_period = 0;
        in_ch.target_id = 0;
        out_ch.ready = 0;
    end

    // Note accepted items and check results on the same sampled edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_item(in_ch.opcode, in_ch.task_handle, in_ch.first_delay,
                             in_ch.repeat_period, in_ch.target_id);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.op_echo, out_ch.success, out_ch.assigned_id,
                                out_ch.run_handle);
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        int burst;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_cycles > 0) begin
                out_ch.ready <= 0;
                repeat (long_hold_cycles) @(posedge i_clk);
                long_hold_cycles = 0;
            end else if (idle_enable && $urandom_range(3, 0) == 0) begin
                burst = $urandom_range(7, 1);
                out_ch.ready <= 0;
                repeat (burst) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input t_op op, input logic [7:0] h, input logic [31:0] dly,
                             input logic [31:0] per, input logic [15:0] tgt);
        int gap;
        if (idle_enable && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(7, 1);
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.opcode <= op;
        in_ch.task_handle <= h;
        in_ch.first_delay <= dly;
        in_ch.repeat_period <= per;
        in_ch.target_id <= tgt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Small delays keep due heads within reach of a few ticks.
    function automatic logic [31:0] pick_delay();
        case ($urandom_range(9, 0))
            0: return 32'hFFFF_FFFF;
            1: return $urandom;
            2: return 0;
            default: return $urandom_range(6, 0);
        endcase
    endfunction

    task automatic send_random();
        int sel;
        logic [15:0] tgt;
        sel = $urandom_range(99, 0);
        if (sel < 35) begin
            send_item(OP_ADD, 8'($urandom), pick_delay(),
                      ($urandom_range(2, 0) == 0) ? 32'h0 : pick_delay(), 16'($urandom));
        end else if (sel < 50) begin
            tgt = ($urandom_range(3, 0) == 0) ? 16'($urandom) : sb.live_id();
            send_item(OP_DELETE, 8'($urandom), $urandom, $urandom, tgt);
        end else if (sel < 75) begin
            send_item(OP_TICK, 8'($urandom), $urandom, $urandom, 16'($urandom));
        end else begin
            send_item(OP_DISPATCH, 8'($urandom), $urandom, $urandom, 16'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty-table corners first.
        send_item(OP_TICK, 8'h00, 0, 0, 16'h0);
        send_item(OP_DISPATCH, 8'h00, 0, 0, 16'h0);
        send_item(OP_DELETE, 8'h00, 0, 0, 16'h0);
        send_item(OP_DELETE, 8'hFF, 0, 0, 16'hFFFF);
        // Equal delays, zero delay (due at once), max values.
        send_item(OP_ADD, 8'hFF, 32'd3, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_ADD, 8'h01, 32'd3, 32'd0, 16'h0);
        send_item(OP_ADD, 8'h02, 32'd0, 32'd2, 16'h0);
        send_item(OP_ADD, 8'h03, 32'hFFFF_FFFF, 32'd0, 16'h0);
        send_item(OP_ADD, 8'h04, 32'd1, 32'd0, 16'h0);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_DISPATCH, 0, 0, 0, 0);
        send_item(OP_DISPATCH, 0, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_DELETE, 0, 0, 0, 16'd2);
        send_item(OP_DELETE, 0, 0, 0, 16'd2);
        send_item(OP_DELETE, 0, 0, 0, 16'd1);
        // Fill the table; entries are left over, so the last adds are refused.
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_item(OP_ADD, 8'($urandom), $urandom_range(5, 0), 32'd0, 0);
        send_item(OP_ADD, 8'hAA, 32'd1, 32'd1, 0);
        wait_drained();

        // Long stall on the result side while items keep coming.
        long_hold_cycles = 300;
        for (int k = 0; k < 12; k++) send_random();
        wait_drained();

        for (int k = 0; k < 380; k++) begin
            if (k == 300) idle_enable = 0;
            send_random();
        end
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: delta_list_task_scheduler.f
+incdir+design
design/dlts_pkg.sv
design/dlts_if.sv
design/dlts_ctrl.sv
design/dlts_datapath.sv
design/delta_list_task_scheduler.sv
tb/sv/tb_delta_list_task_scheduler.sv
